// ===== hw/rtl/truncated_fourier_series_bank_unit_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef TRUNCATED_FOURIER_SERIES_BANK_UNIT_MACROS_SVH
`define TRUNCATED_FOURIER_SERIES_BANK_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define TFSB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tfsb check failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define TFSB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tfsb check failed: next-cycle implication");

`endif

// ===== hw/rtl/tfsb_pkg.sv =====
`default_nettype none
package tfsb_pkg;

    // Command codes of an input item.
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_EVAL  = 2'd1,
        CMD_DERIV = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PULSATION = 2'd0;
    localparam logic [1:0] CFG_ORDER     = 2'd1;
    localparam logic [1:0] CFG_SERIES    = 2'd2;

    localparam logic signed [31:0] PULSATION_RST = 32'sd16777216;
    localparam logic [4:0]         ORDER_RST     = 5'd16;
    localparam logic [4:0]         SERIES_RST    = 5'd16;

    localparam int                 CORDIC_STEPS = 30;
    localparam logic signed [33:0] CORDIC_X0    = 34'sh0_26DD_3B6A;
    localparam logic signed [31:0] ONE_Q30      = 32'sd1073741824;

    localparam longint VAL_MAX = 64'sd549755813887;
    localparam longint VAL_MIN = -64'sd549755813888;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CORDIC,
        S_REC,
        S_RD,
        S_MUL,
        S_P,
        S_W,
        S_K,
        S_ACC,
        S_FIN
    } t_state;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
        logic signed [33:0] r;
        case (i)
            5'd0:  r = 34'sd536870912;
            5'd1:  r = 34'sd316933406;
            5'd2:  r = 34'sd167458907;
            5'd3:  r = 34'sd85004756;
            5'd4:  r = 34'sd42667331;
            5'd5:  r = 34'sd21354465;
            5'd6:  r = 34'sd10679838;
            5'd7:  r = 34'sd5340245;
            5'd8:  r = 34'sd2670163;
            5'd9:  r = 34'sd1335087;
            5'd10: r = 34'sd667544;
            5'd11: r = 34'sd333772;
            5'd12: r = 34'sd166886;
            5'd13: r = 34'sd83443;
            5'd14: r = 34'sd41722;
            5'd15: r = 34'sd20861;
            5'd16: r = 34'sd10430;
            5'd17: r = 34'sd5215;
            5'd18: r = 34'sd2608;
            5'd19: r = 34'sd1304;
            5'd20: r = 34'sd652;
            5'd21: r = 34'sd326;
            5'd22: r = 34'sd163;
            5'd23: r = 34'sd81;
            5'd24: r = 34'sd41;
            5'd25: r = 34'sd20;
            5'd26: r = 34'sd10;
            5'd27: r = 34'sd5;
            5'd28: r = 34'sd3;
            5'd29: r = 34'sd1;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

    // Sine rows; all others are cosine rows with a constant term.
    function automatic logic is_odd_row(input int unsigned l);
        return (l == 1) || (l == 4) || (l == 7) || (l == 9) || (l == 11) || (l == 13);
    endfunction

    // Round half up by 2^30 and clamp to +-1.0 in Q1.30.
    function automatic logic signed [31:0] rnd_clamp_q30(input logic signed [63:0] v);
        logic signed [63:0] t;
        logic signed [31:0] r;
        t = (v + 64'sd536870912) >>> 30;
        if (t > 64'sd1073741824) begin
            r = ONE_Q30;
        end else if (t < -64'sd1073741824) begin
            r = -ONE_Q30;
        end else begin
            r = t[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tfsb_cordic.sv =====
`default_nettype none
module tfsb_cordic (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [31:0]        i_phase,
    output logic                    o_done,
    output logic signed [31:0]      o_cos,
    output logic signed [31:0]      o_sin
);
    import tfsb_pkg::*;

    logic               r_run;
    logic               r_fin;
    logic [4:0]         r_i;
    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic signed [33:0] r_z;
    logic [1:0]         r_q;

    logic [1:0]         ph_q;
    logic [31:0]        ph_d;
    logic signed [33:0] sh_x;
    logic signed [33:0] sh_y;
    logic signed [33:0] rot_c;
    logic signed [33:0] rot_s;

    // Split the phase into a quadrant and a residual angle.
    always_comb begin
        ph_q = 2'((i_phase + 32'h2000_0000) >> 30);
        ph_d = i_phase - {ph_q, 30'd0};
    end

    // Shared shifter of the micro-rotation.
    assign sh_x = r_x >>> r_i;
    assign sh_y = r_y >>> r_i;

    // Control: run the micro-rotations, then flag one cycle of done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_fin <= 1'b0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && (r_i == 5'(CORDIC_STEPS - 1))) begin
                r_run <= 1'b0;
                r_fin <= 1'b1;
            end
        end
    end

    // Datapath: one micro-rotation per cycle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= CORDIC_X0;
            r_y <= '0;
            r_z <= 34'(signed'(ph_d));
            r_q <= ph_q;
            r_i <= '0;
        end else if (r_run) begin
            if (r_z >= 0) begin
                r_x <= r_x - sh_y;
                r_y <= r_y + sh_x;
                r_z <= r_z - atan_turn(r_i);
            end else begin
                r_x <= r_x + sh_y;
                r_y <= r_y - sh_x;
                r_z <= r_z + atan_turn(r_i);
            end
            r_i <= r_i + 5'd1;
        end
    end

    // Rotate back by the quadrant and clamp.
    always_comb begin
        case (r_q)
            2'd0: begin
                rot_c = r_x;
                rot_s = r_y;
            end
            2'd1: begin
                rot_c = -r_y;
                rot_s = r_x;
            end
            2'd2: begin
                rot_c = -r_x;
                rot_s = -r_y;
            end
            default: begin
                rot_c = r_y;
                rot_s = -r_x;
            end
        endcase
        o_cos = rnd_clamp_q30(64'(rot_c) <<< 30);
        o_sin = rnd_clamp_q30(64'(rot_s) <<< 30);
    end

    assign o_done = r_fin;

endmodule
`default_nettype wire

// ===== hw/rtl/truncated_fourier_series_bank_unit.sv =====
`default_nettype none
// Load: taken while idle, busy stays low.
// Evaluate: a CORDIC run, the harmonic recurrence when order exceeds one, then the terms
// of each row; the shared multiplier serves the recurrence and the coefficient and pulsation products.
// One result per row appears on a one-cycle strobe; results cannot be stalled.
// Synchronous active-low reset sets control and configuration to defaults; coefficients are
// undefined until loaded.
module truncated_fourier_series_bank_unit #(
    parameter int MAX_SERIES = 16,
    parameter int MAX_ORDER  = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_command,
    input  wire logic [3:0]         i_series_index,
    input  wire logic [4:0]         i_harmonic_index,
    input  wire logic signed [31:0] i_coef_value,
    input  wire logic [31:0]        i_phase,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    output logic                    o_result_strobe,
    output logic [3:0]              o_result_series,
    output logic signed [39:0]      o_series_value,
    output logic                    o_last_result
);
    import tfsb_pkg::*;

    localparam int ROWLEN = MAX_ORDER + 1;
    localparam int DEPTH  = MAX_SERIES * ROWLEN;
    localparam int AW     = $clog2(DEPTH);
    localparam int KW     = $clog2(MAX_ORDER + 1);
    localparam int HW     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int RW     = $clog2(MAX_SERIES + 1);
    localparam int WKW    = 41 + KW;
    localparam int ACW    = 44 + 2 * KW;

    localparam logic signed [ACW-1:0] ACC_MAX = ACW'(VAL_MAX);
    localparam logic signed [ACW-1:0] ACC_MIN = ACW'(VAL_MIN);

    // Control and configuration
    t_state                 r_state;
    t_state                 n_state;
    logic signed [31:0]     r_pulsation;
    logic [4:0]             r_active_order;
    logic [4:0]             r_active_series;

    // Datapath registers
    logic                   r_deriv;
    logic [KW-1:0]          r_ord;
    logic [RW-1:0]          r_rows;
    logic [KW-1:0]          r_k;
    logic [2:0]             r_ph;
    logic signed [31:0]     r_c1;
    logic signed [31:0]     r_s1;
    logic signed [31:0]     r_cp;
    logic signed [31:0]     r_sp;
    logic signed [31:0]     r_cn;
    logic signed [63:0]     r_sum;
    logic signed [66:0]     r_prod;
    logic signed [32:0]     r_p;
    logic signed [WKW-1:0]  r_wk;
    logic signed [ACW-1:0]  r_acc;
    logic [RW-1:0]          r_row;
    logic [AW-1:0]          r_rowbase;
    logic [AW-1:0]          r_addr;
    logic signed [31:0]     r_coef;
    logic signed [31:0]     r_hc;
    logic signed [31:0]     r_hs;

    // Memories
    logic signed [31:0]     r_mem [DEPTH];
    logic signed [31:0]     r_hcos [MAX_ORDER];
    logic signed [31:0]     r_hsin [MAX_ORDER];

    // Combinational helpers
    logic                   accept;
    logic                   eval_go;
    logic                   load_we;
    logic [AW-1:0]          load_addr;
    logic [KW-1:0]          ord_c;
    logic [RW-1:0]          rows_c;
    logic                   cd_done;
    logic signed [31:0]     cd_cos;
    logic signed [31:0]     cd_sin;
    logic signed [33:0]     mul_a;
    logic signed [32:0]     mul_b;
    logic                   harm_we;
    logic [HW-1:0]          harm_wa;
    logic signed [31:0]     harm_wc;
    logic signed [31:0]     harm_ws;
    logic [HW-1:0]          harm_ra;
    logic                   odd;
    logic signed [31:0]     h_sel;
    logic signed [66:0]     p_full;
    logic signed [66:0]     w_full;
    logic signed [39:0]     w_val;
    logic signed [31:0]     sn_new;
    logic signed [ACW-1:0]  term;
    logic signed [ACW-1:0]  fin_sum;
    logic signed [39:0]     fin_sat;
    logic                   row_last;
    logic                   eval_init;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign eval_go     = accept && ((t_cmd'(i_command) == CMD_EVAL) ||
                                    (t_cmd'(i_command) == CMD_DERIV));
    assign load_we     = accept && (t_cmd'(i_command) == CMD_LOAD) &&
                         (32'(i_series_index) < MAX_SERIES) &&
                         (32'(i_harmonic_index) <= MAX_ORDER);
    assign load_addr   = AW'(AW'(i_series_index) * AW'(ROWLEN) + AW'(i_harmonic_index));

    // Clamp the order and row count registers into range.
    always_comb begin
        if (r_active_order == 5'd0) begin
            ord_c = KW'(1);
        end else if (32'(r_active_order) > MAX_ORDER) begin
            ord_c = KW'(MAX_ORDER);
        end else begin
            ord_c = KW'(r_active_order);
        end
        if (r_active_series == 5'd0) begin
            rows_c = RW'(1);
        end else if (32'(r_active_series) > MAX_SERIES) begin
            rows_c = RW'(MAX_SERIES);
        end else begin
            rows_c = RW'(r_active_series);
        end
    end

    tfsb_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (eval_go),
        .i_phase (i_phase),
        .o_done  (cd_done),
        .o_cos   (cd_cos),
        .o_sin   (cd_sin)
    );

    // Term arithmetic around the shared multiplier
    assign odd      = is_odd_row(32'(r_row));
    assign p_full   = (r_prod + 67'sd536870912) >>> 30;
    assign w_full   = (r_prod + 67'sd8388608) >>> 24;
    assign w_val    = w_full[39:0];
    assign sn_new   = rnd_clamp_q30(r_sum + r_prod[63:0]);
    assign term     = r_deriv ? ACW'(r_wk) : ACW'(r_p);
    assign row_last = ((r_row + RW'(1)) == r_rows);
    assign harm_ra  = (r_k == '0) ? '0 : HW'(r_k - KW'(1));

    always_comb begin
        if (!r_deriv) begin
            h_sel = odd ? r_hs : r_hc;
        end else begin
            h_sel = odd ? r_hc : r_hs;
        end
    end

    // Row result: constant term or derivative sign, then saturate.
    always_comb begin
        if (!r_deriv) begin
            fin_sum = odd ? r_acc : (r_acc + ACW'(r_coef));
        end else begin
            fin_sum = odd ? r_acc : -r_acc;
        end
        if (fin_sum > ACC_MAX) begin
            fin_sat = 40'(ACC_MAX);
        end else if (fin_sum < ACC_MIN) begin
            fin_sat = 40'(ACC_MIN);
        end else begin
            fin_sat = fin_sum[39:0];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (eval_go) begin
                    n_state = S_CORDIC;
                end
            end
            S_CORDIC: begin
                if (cd_done) begin
                    n_state = (r_ord == KW'(1)) ? S_RD : S_REC;
                end
            end
            S_REC: begin
                if ((r_ph == 3'd4) && ((r_k + KW'(1)) == r_ord)) begin
                    n_state = S_RD;
                end
            end
            S_RD:    n_state = (r_k == '0) ? S_FIN : S_MUL;
            S_MUL:   n_state = S_P;
            S_P:     n_state = r_deriv ? S_W : S_ACC;
            S_W:     n_state = S_K;
            S_K:     n_state = S_ACC;
            S_ACC:   n_state = S_RD;
            S_FIN:   n_state = row_last ? S_IDLE : S_RD;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: multiplier operands and harmonic writes
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        harm_we = 1'b0;
        harm_wa = '0;
        harm_wc = cd_cos;
        harm_ws = cd_sin;
        unique case (r_state)
            S_CORDIC: begin
                harm_we = cd_done;
            end
            S_REC: begin
                case (r_ph)
                    3'd0: begin
                        mul_a = 34'(r_cp);
                        mul_b = 33'(r_c1);
                    end
                    3'd1: begin
                        mul_a = 34'(r_sp);
                        mul_b = 33'(r_s1);
                    end
                    3'd2: begin
                        mul_a = 34'(r_sp);
                        mul_b = 33'(r_c1);
                    end
                    3'd3: begin
                        mul_a = 34'(r_cp);
                        mul_b = 33'(r_s1);
                    end
                    default: begin
                        harm_we = 1'b1;
                        harm_wa = HW'(r_k);
                        harm_wc = r_cn;
                        harm_ws = sn_new;
                    end
                endcase
            end
            S_MUL: begin
                mul_a = 34'(r_coef);
                mul_b = 33'(h_sel);
            end
            S_W: begin
                mul_a = 34'(r_p);
                mul_b = 33'(r_pulsation);
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    assign eval_init = (n_state == S_RD) && ((r_state == S_CORDIC) || (r_state == S_REC));

    // Control registers, configuration and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_pulsation     <= PULSATION_RST;
            r_active_order  <= ORDER_RST;
            r_active_series <= SERIES_RST;
            o_result_strobe <= 1'b0;
            o_last_result   <= 1'b0;
        end else begin
            r_state         <= n_state;
            o_result_strobe <= (r_state == S_FIN);
            o_last_result   <= (r_state == S_FIN) && row_last;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PULSATION: r_pulsation     <= i_cfg_data;
                    CFG_ORDER:     r_active_order  <= i_cfg_data[4:0];
                    CFG_SERIES:    r_active_series <= i_cfg_data[4:0];
                    default:       r_pulsation     <= r_pulsation;
                endcase
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN) begin
            o_result_series <= r_row[3:0];
            o_series_value  <= fin_sat;
        end
    end

    // Datapath sequence
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (eval_init) begin
            // Start the first row once the harmonics are in place
            r_row     <= '0;
            r_rowbase <= '0;
            r_addr    <= AW'(r_ord);
            r_k       <= r_ord;
            r_acc     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (eval_go) begin
                        r_deriv <= (t_cmd'(i_command) == CMD_DERIV);
                        r_ord   <= ord_c;
                        r_rows  <= rows_c;
                    end
                end
                S_CORDIC: begin
                    if (cd_done) begin
                        r_c1 <= cd_cos;
                        r_s1 <= cd_sin;
                        r_cp <= cd_cos;
                        r_sp <= cd_sin;
                        r_k  <= KW'(1);
                        r_ph <= '0;
                    end
                end
                S_REC: begin
                    case (r_ph)
                        3'd1:    r_sum <= r_prod[63:0];
                        3'd2:    r_cn  <= rnd_clamp_q30(r_sum - r_prod[63:0]);
                        3'd3:    r_sum <= r_prod[63:0];
                        3'd4: begin
                            r_cp <= r_cn;
                            r_sp <= sn_new;
                            r_k  <= r_k + KW'(1);
                        end
                        default: r_sum <= r_sum;
                    endcase
                    r_ph <= (r_ph == 3'd4) ? 3'd0 : r_ph + 3'd1;
                end
                S_P: begin
                    r_p <= p_full[32:0];
                end
                S_K: begin
                    r_wk <= w_val * $signed({1'b0, r_k});
                end
                S_ACC: begin
                    r_acc  <= r_acc + term;
                    r_k    <= r_k - KW'(1);
                    r_addr <= r_addr - AW'(1);
                end
                S_FIN: begin
                    r_row     <= r_row + RW'(1);
                    r_rowbase <= r_rowbase + AW'(ROWLEN);
                    r_addr    <= r_rowbase + AW'(ROWLEN) + AW'(r_ord);
                    r_k       <= r_ord;
                    r_acc     <= '0;
                end
                default: begin
                    r_acc <= r_acc;
                end
            endcase
        end
    end

    // Coefficient bank: write on load, registered read per term
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            r_mem[load_addr] <= i_coef_value;
        end
        if (r_state == S_RD) begin
            r_coef <= r_mem[r_addr];
        end
    end

    // Harmonic store: cos and sin of k*phase
    always_ff @(posedge i_clk) begin
        if (harm_we) begin
            r_hcos[harm_wa] <= harm_wc;
            r_hsin[harm_wa] <= harm_ws;
        end
        if (r_state == S_RD) begin
            r_hc <= r_hcos[harm_ra];
            r_hs <= r_hsin[harm_ra];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/tfsb_checker.sv =====
`default_nettype none
`include "truncated_fourier_series_bank_unit_macros.svh"
module tfsb_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [1:0] i_command,
    input wire logic       o_result_strobe,
    input wire logic       o_last_result
);
    import tfsb_pkg::*;

    // An accepted evaluate holds the block busy.
    `TFSB_ASSERT_NEXT(a_eval_busy, start && !busy && (i_command inside {CMD_EVAL, CMD_DERIV}), busy)

    // A load or empty command leaves the block free.
    `TFSB_ASSERT_NEXT(a_load_free, start && !busy && (i_command == CMD_LOAD || i_command == CMD_NONE), !busy)

    // Results only follow a busy cycle.
    `TFSB_ASSERT_IMPL(a_result_busy, o_result_strobe, $past(busy))

    // The last flag only rides on a result transfer.
    `TFSB_ASSERT_IMPL(a_last_strobe, o_last_result, o_result_strobe)

endmodule

bind truncated_fourier_series_bank_unit tfsb_checker u_tfsb_checker (.*);
`default_nettype wire
